/* rtl/kpvf_pkg.sv */
package kpvf_pkg;

  // payload and state widths
  localparam int VALUE_WIDTH = 32;
  localparam int COV_WIDTH   = 48;
  localparam int TS_W        = 21;
  localparam int AV_W        = 31;
  localparam int Z_W         = 32;
  localparam int R_W         = 31;
  localparam int OUT_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 31;
  // dt^4 >> 32 is the widest power of the time step
  localparam int DT_W        = 4 * TS_W - 32;
  localparam int Y_W         = ((VALUE_WIDTH > Z_W) ? VALUE_WIDTH : Z_W) + 1;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_VAR = CFG_IDX_W'(1);
  localparam logic [TS_W-1:0]      TS_RESET      = TS_W'(6554);
  localparam logic [AV_W-1:0]      AV_RESET      = AV_W'(65536);

  localparam logic OPC_MEASURE = 1'b0;
  localparam logic OPC_CLEAR   = 1'b1;

  // micro-program
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_LAST_PREDICT = STEP_W'(9);
  localparam logic [STEP_W-1:0] STEP_LAST         = STEP_W'(14);

  typedef enum logic {K_MUL, K_DIV} kind_t;

  typedef enum logic [3:0] {
    S_D, S_D2, S_Q, S_DT2, S_DT3, S_DT4, S_POS, S_VEL, S_PAA, S_PAV, S_PVV, S_Y
  } src_t;

  typedef enum logic [2:0] {
    D_DT2, D_DT3, D_DT4, D_POS, D_VEL, D_PAA, D_PAV, D_PVV
  } dst_t;

  typedef enum logic [2:0] {SH0, SH16, SH24, SH25, SH26, SH32} shift_t;

  typedef enum logic [1:0] {W64, WVAL, WCOV, W32} width_t;

  typedef struct packed {
    kind_t  kind;
    src_t   a;
    src_t   b;
    shift_t sh;
    width_t wu;
    logic   neg;
    dst_t   dst;
  } op_t;

  typedef struct packed {
    logic load_in;
    logic clear_state;
    logic op_start;
    op_t  op;
    logic calc_ys;
    logic out_load;
    logic out_skip;
  } dp_cmd_t;

  typedef struct packed {
    logic op_done;
    logic ts_zero;
    logic s_pos;
  } dp_stat_t;

  function automatic op_t prog_op(input logic [STEP_W-1:0] idx);
    op_t o;
    begin
      case (idx)
        4'd0:    o = '{K_MUL, S_D,   S_D,   SH0,  W64,  1'b0, D_DT2};
        4'd1:    o = '{K_MUL, S_DT2, S_D,   SH16, W64,  1'b0, D_DT3};
        4'd2:    o = '{K_MUL, S_DT3, S_D,   SH16, W64,  1'b0, D_DT4};
        4'd3:    o = '{K_MUL, S_VEL, S_D,   SH16, WVAL, 1'b0, D_POS};
        4'd4:    o = '{K_MUL, S_PAV, S_D2,  SH16, WCOV, 1'b0, D_PAA};
        4'd5:    o = '{K_MUL, S_PVV, S_DT2, SH32, WCOV, 1'b0, D_PAA};
        4'd6:    o = '{K_MUL, S_Q,   S_DT4, SH26, WCOV, 1'b0, D_PAA};
        4'd7:    o = '{K_MUL, S_PVV, S_D,   SH16, WCOV, 1'b0, D_PAV};
        4'd8:    o = '{K_MUL, S_Q,   S_DT3, SH25, WCOV, 1'b0, D_PAV};
        4'd9:    o = '{K_MUL, S_Q,   S_DT2, SH24, WCOV, 1'b0, D_PVV};
        4'd10:   o = '{K_DIV, S_PAA, S_Y,   SH0,  W64,  1'b0, D_POS};
        4'd11:   o = '{K_DIV, S_PAV, S_Y,   SH0,  W64,  1'b0, D_VEL};
        4'd12:   o = '{K_DIV, S_PAV, S_PAV, SH0,  WCOV, 1'b1, D_PVV};
        4'd13:   o = '{K_DIV, S_PAV, S_PAA, SH0,  WCOV, 1'b1, D_PAV};
        4'd14:   o = '{K_DIV, S_PAA, S_PAA, SH0,  WCOV, 1'b1, D_PAA};
        default: o = '{K_MUL, S_D,   S_D,   SH0,  W64,  1'b0, D_DT2};
      endcase
      return o;
    end
  endfunction

endpackage

/* rtl/kpvf_datapath.sv */
module kpvf_datapath import kpvf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic [IN_DATA_W-1:0]    in_data,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  output logic [OUT_DATA_W-1:0]   out_data,
  output logic                    out_skip
);

  typedef enum logic [4:0] {
    P_IDLE  = 5'b00001,
    P_MUL   = 5'b00010,
    P_DIV   = 5'b00100,
    P_ROUND = 5'b01000,
    P_WRITE = 5'b10000
  } phase_t;

  logic [TS_W-1:0]              time_step;
  logic [AV_W-1:0]              accel_var;
  logic signed [Z_W-1:0]        z;
  logic [R_W-1:0]               r;
  logic signed [VALUE_WIDTH-1:0] pos, vel;
  logic signed [COV_WIDTH-1:0]  paa, pav, pvv;
  logic [DT_W-1:0]              dt2, dt3, dt4;
  logic signed [Y_W-1:0]        y;
  logic signed [63:0]           s;

  phase_t       phase;
  op_t          op_q;
  logic [63:0]  a_mag, b_mag;
  logic         neg_q;
  logic [127:0] acc;
  logic [63:0]  rem;
  logic [6:0]   cnt;
  logic [128:0] mag;

  function automatic int width_bits(input width_t w);
    case (w)
      W64:     return 64;
      WVAL:    return VALUE_WIDTH;
      WCOV:    return COV_WIDTH;
      W32:     return OUT_W;
      default: return 64;
    endcase
  endfunction

  function automatic logic [63:0] magn(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [65:0] clampw(input logic signed [65:0] x, input int n);
    logic signed [65:0] mx, mn;
    begin
      mx = signed'((66'(1) << (n - 1)) - 66'(1));
      mn = -mx - 66'sd1;
      if (x > mx) return mx;
      if (x < mn) return mn;
      return x;
    end
  endfunction

  // magnitude to signed value, saturated to n bits
  function automatic logic signed [65:0] pack_mag(input logic neg, input logic [128:0] m,
                                                  input int n);
    logic [128:0] lim, v;
    begin
      lim = 129'(1) << (n - 1);
      if (neg) begin
        v = (m > lim) ? lim : m;
        return -signed'({2'b00, v[63:0]});
      end
      v = (m > lim - 129'(1)) ? lim - 129'(1) : m;
      return signed'({2'b00, v[63:0]});
    end
  endfunction

  function automatic logic [128:0] round_shift(input logic [127:0] p, input int n);
    return 129'(p >> n) + 129'(p[n - 1]);
  endfunction

  function automatic logic signed [63:0] operand(input src_t sel);
    case (sel)
      S_D:     return 64'(time_step);
      S_D2:    return 64'({time_step, 1'b0});
      S_Q:     return 64'(accel_var);
      S_DT2:   return 64'(dt2);
      S_DT3:   return 64'(dt3);
      S_DT4:   return 64'(dt4);
      S_POS:   return 64'(pos);
      S_VEL:   return 64'(vel);
      S_PAA:   return 64'(paa);
      S_PAV:   return 64'(pav);
      S_PVV:   return 64'(pvv);
      S_Y:     return 64'(y);
      default: return 64'sd0;
    endcase
  endfunction

  logic signed [63:0] opa, opb;
  logic [15:0]        b_chunk;
  logic [79:0]        pp;
  logic [127:0]       pp_shifted;
  logic [64:0]        rem2;
  logic               ge;
  logic [63:0]        s_u;
  logic signed [65:0] packed_v, signed_v, cur, clamped, wr_val;
  int                 dst_n;
  logic signed [65:0] s_sum;
  logic signed [65:0] out_pos, out_vel;

  assign opa = operand(cmd.op.a);
  assign opb = operand(cmd.op.b);
  assign s_u = s;

  always_comb begin
    case (cnt[1:0])
      2'd0:    b_chunk = b_mag[15:0];
      2'd1:    b_chunk = b_mag[31:16];
      2'd2:    b_chunk = b_mag[47:32];
      default: b_chunk = b_mag[63:48];
    endcase
    pp         = a_mag * b_chunk;
    pp_shifted = 128'(pp) << {cnt[1:0], 4'b0000};
    rem2       = {rem, acc[127]};
    ge         = rem2 >= {1'b0, s_u};
  end

  // write-back: saturate rounded result, optional negate, then saturating accumulate
  always_comb begin
    packed_v = pack_mag(neg_q, mag, width_bits(op_q.wu));
    signed_v = op_q.neg ? -packed_v : packed_v;
    case (op_q.dst)
      D_POS:   begin cur = 66'(pos); dst_n = VALUE_WIDTH; end
      D_VEL:   begin cur = 66'(vel); dst_n = VALUE_WIDTH; end
      D_PAA:   begin cur = 66'(paa); dst_n = COV_WIDTH; end
      D_PAV:   begin cur = 66'(pav); dst_n = COV_WIDTH; end
      D_PVV:   begin cur = 66'(pvv); dst_n = COV_WIDTH; end
      default: begin cur = 66'sd0;   dst_n = 64; end
    endcase
    clamped = clampw(signed_v, dst_n);
    wr_val  = clampw(cur + clamped, dst_n);
  end

  always_comb begin
    s_sum   = clampw(66'(paa) + signed'(66'({r, 8'b0000_0000})), 64);
    out_pos = clampw(66'(pos), OUT_W);
    out_vel = clampw(66'(vel), OUT_W);
  end

  assign stat.op_done = (phase == P_WRITE);
  assign stat.ts_zero = (time_step == '0);
  assign stat.s_pos   = !s[63] && (s != 64'sd0);

  // configuration and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= TS_RESET;
      accel_var <= AV_RESET;
      pos <= '0;
      vel <= '0;
      paa <= '0;
      pav <= '0;
      pvv <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_TIME_STEP: time_step <= cfg_data[TS_W-1:0];
          CFG_ACCEL_VAR: accel_var <= cfg_data[AV_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clear_state) begin
        pos <= '0;
        vel <= '0;
        paa <= '0;
        pav <= '0;
        pvv <= '0;
      end else if (phase == P_WRITE) begin
        case (op_q.dst)
          D_POS:   pos <= wr_val[VALUE_WIDTH-1:0];
          D_VEL:   vel <= wr_val[VALUE_WIDTH-1:0];
          D_PAA:   paa <= wr_val[COV_WIDTH-1:0];
          D_PAV:   pav <= wr_val[COV_WIDTH-1:0];
          D_PVV:   pvv <= wr_val[COV_WIDTH-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload, time-power and output registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      z <= in_data[Z_W-1:0];
      r <= in_data[Z_W+R_W-1:Z_W];
    end
    if (cmd.calc_ys) begin
      y <= Y_W'(z) - Y_W'(pos);
      s <= s_sum[63:0];
    end
    if (phase == P_WRITE) begin
      case (op_q.dst)
        D_DT2:   dt2 <= wr_val[DT_W-1:0];
        D_DT3:   dt3 <= wr_val[DT_W-1:0];
        D_DT4:   dt4 <= wr_val[DT_W-1:0];
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      out_data <= {out_vel[OUT_W-1:0], out_pos[OUT_W-1:0]};
      out_skip <= cmd.out_skip;
    end
  end

  // shared multiply / divide unit
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
    end else begin
      case (phase)
        P_IDLE: begin
          if (cmd.op_start) phase <= P_MUL;
        end
        P_MUL: begin
          if (cnt[1:0] == 2'd3) phase <= (op_q.kind == K_DIV) ? P_DIV : P_ROUND;
        end
        P_DIV: begin
          if (cnt == 7'd127) phase <= P_ROUND;
        end
        P_ROUND: phase <= P_WRITE;
        P_WRITE: phase <= P_IDLE;
        default: phase <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      P_IDLE: begin
        op_q  <= cmd.op;
        a_mag <= magn(opa);
        b_mag <= magn(opb);
        neg_q <= opa[63] ^ opb[63];
        acc   <= '0;
        rem   <= '0;
        cnt   <= '0;
      end
      P_MUL: begin
        acc <= acc + pp_shifted;
        cnt <= (cnt[1:0] == 2'd3) ? 7'd0 : cnt + 7'd1;
      end
      P_DIV: begin
        rem <= ge ? 64'(rem2 - {1'b0, s_u}) : rem2[63:0];
        acc <= {acc[126:0], ge};
        cnt <= cnt + 7'd1;
      end
      P_ROUND: begin
        if (op_q.kind == K_DIV) begin
          mag <= 129'(acc) + 129'(rem >= s_u - rem);
        end else begin
          case (op_q.sh)
            SH16:    mag <= round_shift(acc, 16);
            SH24:    mag <= round_shift(acc, 24);
            SH25:    mag <= round_shift(acc, 25);
            SH26:    mag <= round_shift(acc, 26);
            SH32:    mag <= round_shift(acc, 32);
            default: mag <= 129'(acc);
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/kpvf_ctrl.sv */
module kpvf_ctrl import kpvf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_opcode,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ISSUE  = 6'b000010,
    ST_RUN    = 6'b000100,
    ST_YS     = 6'b001000,
    ST_CHECK  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              skip, skip_next;
  logic              accept, slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    step_next  = step;
    skip_next  = skip;
    cmd        = '0;
    cmd.op     = prog_op(step);
    cmd.out_skip = skip;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load_in = 1'b1;
          step_next   = '0;
          skip_next   = 1'b0;
          if (in_opcode == OPC_CLEAR) begin
            cmd.clear_state = 1'b1;
            state_next = ST_FINISH;
          end else if (stat.ts_zero) begin
            skip_next  = 1'b1;
            state_next = ST_FINISH;
          end else begin
            state_next = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        cmd.op_start = 1'b1;
        state_next   = ST_RUN;
      end
      ST_RUN: begin
        if (stat.op_done) begin
          if (step == STEP_LAST_PREDICT) begin
            state_next = ST_YS;
          end else if (step == STEP_LAST) begin
            state_next = ST_FINISH;
          end else begin
            step_next  = step + STEP_W'(1);
            state_next = ST_ISSUE;
          end
        end
      end
      ST_YS: begin
        cmd.calc_ys = 1'b1;
        state_next  = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.s_pos) begin
          step_next  = step + STEP_W'(1);
          state_next = ST_ISSUE;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      skip      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      skip  <= skip_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/kalman_position_velocity_filter.sv */
// Two-state (position, velocity) Kalman filter in fixed point: values Q16.16,
// covariances Q24.24, every rounding to nearest with ties away from zero and
// every result saturated. Each input transaction is a measurement (opcode 0)
// or a clear command (opcode 1) and gives exactly one output transaction.
// A measurement runs the predict and then the update. Ten multiply steps
// (issue, four partial products on the shared 64x16 multiplier, round,
// write-back) make up the predict. The innovation and its variance are then
// formed and checked. Five multiply-divide steps follow, each with a 128-step
// restoring divider, and then the output register is loaded. A measurement
// whose innovation variance is not positive gives its result after the
// predict, without the update. A clear command, or a measurement with a zero
// time step (flagged in m_tuser), goes straight to the output register.
// A finished result waits in the last state while the output register still
// holds an earlier result that m_tready has not taken. One item is in work at
// a time; the next may be accepted while the previous result still waits in
// the output register. Configuration writes are registered and must only be
// issued while the filter is idle.
module kalman_position_velocity_filter import kpvf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration: index 0 time_step, index 1 accel_variance
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // [31:0] measured_position, [62:32] measurement_variance
  input  logic                  s_tuser,  // [0] opcode
  // output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // [31:0] position_estimate, [63:32] velocity_estimate
  output logic                  m_tuser   // [0] skipped
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: walks the predict/update micro-program
  kpvf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_opcode (s_tuser),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // filter state, config registers, multiply/divide unit, output register
  kpvf_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (m_tdata),
    .out_skip  (m_tuser)
  );

endmodule

/* rtl/kpvf_checker.sv */
module kpvf_checker import kpvf_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_wr_en,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [IN_DATA_W-1:0]  s_tdata,
  input logic                  s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // one item in work: input closes after a transaction
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input still open after transaction");

  // a new result is presented only as the block returns to idle
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result presented while busy");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind kalman_position_velocity_filter kpvf_checker u_kpvf_checker (.*);
